// File: design/tma_pkg.sv
// shared constants, types and state encodings for the tile mosaic average block
package tma_pkg;

  // frame and tile limits
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MAX_TILE    = 64;

  // field and counter widths
  localparam int DIM_W       = 12;
  localparam int TILE_W      = 7;
  localparam int POS_W       = 11;
  localparam int OFS_W       = 6;
  localparam int CH_W        = 8;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 13;
  localparam int STEP_W      = 3;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // stream word widths
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_SIZE    = 2'd2
  } reg_index_t;

  // clamped frame geometry
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [TILE_W-1:0] tile;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  // one completed tile waiting for division
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    sums_t            sums;
    logic [CNT_W-1:0] count;
    logic             last;
  } tile_entry_t;

  // queue handshake seen from the front
  typedef struct packed {
    logic        push;
    tile_entry_t entry;
  } queue_wr_t;

  typedef enum logic {
    F_IDLE,
    F_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// File: design/tile_mosaic_average.sv
// Tile mosaic average: per tile channel means over a raster pixel stream.
// Input: a new word is taken only after the column sum memory read and write back of the last one.
// Each completed tile passes through the divider in turn (load, 8 quotient bits, output),
// so tiles closing faster than the divider drains them back up the 4-entry queue and then the input.
// A closing word passes the accumulate stage, the tile queue, the divider and the output register.
// Reset: synchronous; positions clear, registers load 640 x 480 with 8-pixel tiles.
module tile_mosaic_average (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tma_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [tma_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // frame_start [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tile_column [10:0], tile_row [21:11], avg_red [29:22], avg_green [37:30],
  // avg_blue [45:38], zero fill [47:46]
  output logic [tma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // last_tile
  output logic                            m_axis_tlast
);
  import tma_pkg::*;

  logic [DIM_W-1:0]  image_width, image_height;
  logic [TILE_W-1:0] tile_size;
  logic              restart;
  cfg_t              cfg;

  queue_wr_t         q_wr;
  tile_entry_t       q_entry;
  logic              q_full, q_empty, q_pop;
  logic              front_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      tile_size    <= TILE_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_TILE_SIZE:    tile_size    <= cfg_data[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  // any known register write restarts the raster position
  assign restart = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                              (cfg_index == REG_IMAGE_HEIGHT) ||
                              (cfg_index == REG_TILE_SIZE));

  // clamp geometry to the supported range, zero counts as one
  always_comb begin
    if (image_width == '0)                     cfg.width = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH))  cfg.width = DIM_W'(MAX_WIDTH);
    else                                       cfg.width = image_width;
    if (image_height == '0)                    cfg.height = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) cfg.height = DIM_W'(MAX_HEIGHT);
    else                                       cfg.height = image_height;
    if (tile_size == '0)                       cfg.tile = TILE_W'(1);
    else if (tile_size > TILE_W'(MAX_TILE))    cfg.tile = TILE_W'(MAX_TILE);
    else                                       cfg.tile = tile_size;
  end

  tma_front u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .busy          (front_busy)
  );

  tma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .pop       (q_pop),
    .entry_out (q_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  tma_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  // front never pushes a tile into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_wr.push && q_full))
    else $error("tile queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("tile queue underflow");

  // accumulate stage always hands back to idle in the next cycle
  a_front_one_cycle: assert property (@(posedge clk) disable iff (rst)
    front_busy |=> !front_busy)
    else $error("front accumulate stage stuck");
`endif

endmodule

// File: design/tma_front.sv
// front end: raster position tracking and per tile column accumulation
module tma_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             restart,
  input  tma_pkg::cfg_t                    cfg,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [tma_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // frame_start [0]
  input  logic                             s_axis_tuser,
  input  logic                             q_full,
  output tma_pkg::queue_wr_t               q_wr,
  output logic                             busy
);
  import tma_pkg::*;

  front_state_t state, state_next;

  // position counters
  logic [POS_W-1:0] pixel_x, pixel_y, tile_x, tile_y;
  logic [OFS_W-1:0] ofs_x, ofs_y;

  // current position after an optional frame restart
  logic [POS_W-1:0] cur_x, cur_y, cur_tx, cur_ty;
  logic [OFS_W-1:0] cur_ox, cur_oy;
  logic [DIM_W-1:0] x_inc, y_inc;
  logic [TILE_W-1:0] ox_inc, oy_inc;
  logic first_px, col_last, row_last, end_x, end_y;

  // next position
  logic [POS_W-1:0] pixel_x_next, pixel_y_next, tile_x_next, tile_y_next;
  logic [OFS_W-1:0] ofs_x_next, ofs_y_next;

  // accumulate stage registers
  logic [CH_W-1:0]   pix_red, pix_green, pix_blue;
  logic              first_r, emit_r, last_r;
  logic [POS_W-1:0]  col_r, row_r;
  logic [TILE_W-1:0] ext_w, ext_h;
  sums_t             rd_sums, sum_new;
  logic [2*TILE_W-1:0] area;

  logic [3*SUM_W-1:0] mem [MAX_WIDTH];

  logic accept;

  assign s_axis_tready = (state == F_IDLE) && !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign busy          = (state == F_ACC);

  // position decode for the incoming word
  always_comb begin
    cur_x    = s_axis_tuser ? '0 : pixel_x;
    cur_y    = s_axis_tuser ? '0 : pixel_y;
    cur_tx   = s_axis_tuser ? '0 : tile_x;
    cur_ty   = s_axis_tuser ? '0 : tile_y;
    cur_ox   = s_axis_tuser ? '0 : ofs_x;
    cur_oy   = s_axis_tuser ? '0 : ofs_y;
    x_inc    = {1'b0, cur_x} + DIM_W'(1);
    y_inc    = {1'b0, cur_y} + DIM_W'(1);
    ox_inc   = {1'b0, cur_ox} + TILE_W'(1);
    oy_inc   = {1'b0, cur_oy} + TILE_W'(1);
    first_px = (cur_ox == '0) && (cur_oy == '0);
    col_last = (x_inc >= cfg.width);
    row_last = (y_inc >= cfg.height);
    end_x    = (ox_inc == cfg.tile) || col_last;
    end_y    = (oy_inc == cfg.tile) || row_last;

    // advance along the line
    pixel_x_next = x_inc[POS_W-1:0];
    pixel_y_next = cur_y;
    tile_x_next  = cur_tx;
    tile_y_next  = cur_ty;
    ofs_x_next   = ox_inc[OFS_W-1:0];
    ofs_y_next   = cur_oy;
    if (ox_inc >= cfg.tile) begin
      ofs_x_next  = '0;
      tile_x_next = cur_tx + POS_W'(1);
    end
    // wrap to the next line, then to the next frame
    if (col_last) begin
      pixel_x_next = '0;
      ofs_x_next   = '0;
      tile_x_next  = '0;
      pixel_y_next = y_inc[POS_W-1:0];
      ofs_y_next   = oy_inc[OFS_W-1:0];
      if (oy_inc >= cfg.tile) begin
        ofs_y_next  = '0;
        tile_y_next = cur_ty + POS_W'(1);
      end
      if (row_last) begin
        pixel_y_next = '0;
        ofs_y_next   = '0;
        tile_y_next  = '0;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_ACC;
      F_ACC:  state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_x <= '0;
      pixel_y <= '0;
      tile_x  <= '0;
      tile_y  <= '0;
      ofs_x   <= '0;
      ofs_y   <= '0;
    end else if (accept) begin
      pixel_x <= pixel_x_next;
      pixel_y <= pixel_y_next;
      tile_x  <= tile_x_next;
      tile_y  <= tile_y_next;
      ofs_x   <= ofs_x_next;
      ofs_y   <= ofs_y_next;
    end
  end

  // capture the word and its tile context
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_red   <= s_axis_tdata[CH_W-1:0];
      pix_green <= s_axis_tdata[2*CH_W-1:CH_W];
      pix_blue  <= s_axis_tdata[3*CH_W-1:2*CH_W];
      first_r   <= first_px;
      emit_r    <= end_x && end_y;
      last_r    <= col_last && row_last;
      col_r     <= cur_tx;
      row_r     <= cur_ty;
      ext_w     <= ox_inc;
      ext_h     <= oy_inc;
    end
  end

  // column sum memory: read on accept, write back in the next cycle, in the accumulate state
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sums <= sums_t'(mem[cur_tx[ADDR_W-1:0]]);
    end
    if (state == F_ACC) begin
      mem[col_r[ADDR_W-1:0]] <= emit_r ? '0 : sum_new;
    end
  end

  // first word of a tile loads, the rest add
  always_comb begin
    sum_new.red   = first_r ? SUM_W'(pix_red)   : rd_sums.red   + SUM_W'(pix_red);
    sum_new.green = first_r ? SUM_W'(pix_green) : rd_sums.green + SUM_W'(pix_green);
    sum_new.blue  = first_r ? SUM_W'(pix_blue)  : rd_sums.blue  + SUM_W'(pix_blue);
    area          = ext_w * ext_h;
    q_wr.push        = (state == F_ACC) && emit_r;
    q_wr.entry.col   = col_r;
    q_wr.entry.row   = row_r;
    q_wr.entry.sums  = sum_new;
    q_wr.entry.count = area[CNT_W-1:0];
    q_wr.entry.last  = last_r;
  end

endmodule

// File: design/tma_queue.sv
// short queue of completed tiles between the front and back ends
module tma_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  tma_pkg::queue_wr_t    wr,
  input  logic                  pop,
  output tma_pkg::tile_entry_t  entry_out,
  output logic                  full,
  output logic                  empty
);
  import tma_pkg::*;

  tile_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign entry_out = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)     rd_ptr <= rd_ptr + QPTR_W'(1);
      if (wr.push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !wr.push) count <= count - (QPTR_W+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr.push) slots[wr_ptr] <= wr.entry;
  end

endmodule

// File: design/tma_back.sv
// back end: bit serial division of the tile sums and the output register
module tma_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  tma_pkg::tile_entry_t            q_entry,
  output logic                            q_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tile_column [10:0], tile_row [21:11], avg_red [29:22], avg_green [37:30],
  // avg_blue [45:38], zero fill [47:46]
  output logic [tma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // last_tile
  output logic                            m_axis_tlast
);
  import tma_pkg::*;

  back_state_t state, state_next;

  logic [SUM_W-1:0]  rem_red, rem_green, rem_blue;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic [CH_W-1:0]   quo_red, quo_green, quo_blue;
  logic [POS_W-1:0]  col_r, row_r;
  logic              last_r;

  logic [SUM_W-1:0]  div_sh;
  logic              ge_red, ge_green, ge_blue;
  logic              out_free;

  logic [POS_W-1:0]  out_col, out_row;
  logic [CH_W-1:0]   out_red, out_green, out_blue;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // one quotient bit per cycle for all three channels
  always_comb begin
    div_sh   = SUM_W'(divisor) << step;
    ge_red   = (rem_red   >= div_sh);
    ge_green = (rem_green >= div_sh);
    ge_blue  = (rem_blue  >= div_sh);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_DIV;
      B_DIV:  if (step == '0) state_next = B_DONE;
      B_DONE: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_red   <= q_entry.sums.red;
      rem_green <= q_entry.sums.green;
      rem_blue  <= q_entry.sums.blue;
      divisor   <= q_entry.count;
      step      <= STEP_W'(CH_W - 1);
      col_r     <= q_entry.col;
      row_r     <= q_entry.row;
      last_r    <= q_entry.last;
    end else if (state == B_DIV) begin
      if (ge_red)   rem_red   <= rem_red   - div_sh;
      if (ge_green) rem_green <= rem_green - div_sh;
      if (ge_blue)  rem_blue  <= rem_blue  - div_sh;
      quo_red   <= {quo_red[CH_W-2:0], ge_red};
      quo_green <= {quo_green[CH_W-2:0], ge_green};
      quo_blue  <= {quo_blue[CH_W-2:0], ge_blue};
      step      <= step - STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == B_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && out_free) begin
      out_col      <= col_r;
      out_row      <= row_r;
      out_red      <= quo_red;
      out_green    <= quo_green;
      out_blue     <= quo_blue;
      m_axis_tlast <= last_r;
    end
  end

  assign m_axis_tdata = {2'b00, out_blue, out_green, out_red, out_row, out_col};

endmodule
